@@ rtl/crcdf_pkg.sv @@
`default_nettype none
package crcdf_pkg;

  localparam int MAX_FRAME_BYTES   = 64;
  localparam int MAX_PAYLOAD_BYTES = 32;
  localparam int TELEMETRY_BYTES   = 24;
  localparam int HDR_BYTES         = 6;
  localparam int CRC_TAIL_BYTES    = 2;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam int FILL_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);
  localparam int IDX_W  = 5;
  localparam int LEN_W  = 9;
  localparam int PC_W   = 4;
  localparam int CNT_W  = 32;

  typedef enum logic [1:0] {
    EV_CRC_ERR   = 2'd0,
    EV_PROTO_ERR = 2'd1,
    EV_PAYLOAD   = 2'd2
  } event_e;

  typedef enum logic [1:0] {
    CFG_MARK_FIRST  = 2'd0,
    CFG_MARK_SECOND = 2'd1,
    CFG_VERSION     = 2'd2,
    CFG_TYPE_CODE   = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_ACCEPT,
    ACT_HUNT,
    ACT_STORE,
    ACT_CLEAR,
    ACT_START_RUN,
    ACT_EMIT_PAY,
    ACT_EMIT_ERR
  } action_e;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_FILL_LT2,
    C_FILL_FULL,
    C_LEN_BAD,
    C_NOT_DONE,
    C_CRC_BAD,
    C_PROTO_BAD,
    C_NOT_TELEM,
    C_NOT_LAST
  } cond_e;

  typedef struct packed {
    action_e         act;
    cond_e           cond;
    logic [PC_W-1:0] target;
    logic            wait_out;
  } ucode_t;

  // Byte-wise CRC-16/Modbus update, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

  // Sequencer program. Taken jump goes to target, otherwise falls through.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '{act: ACT_NOP, cond: C_ALWAYS, target: PC_W'(0), wait_out: 1'b0};
    case (pc)
      4'd0:  w = '{ACT_ACCEPT,    C_NO_INPUT,  PC_W'(0),  1'b0};
      4'd1:  w = '{ACT_NOP,       C_FILL_LT2,  PC_W'(14), 1'b0};
      4'd2:  w = '{ACT_NOP,       C_FILL_FULL, PC_W'(15), 1'b0};
      4'd3:  w = '{ACT_STORE,     C_NEVER,     PC_W'(0),  1'b0};
      4'd4:  w = '{ACT_NOP,       C_LEN_BAD,   PC_W'(15), 1'b0};
      4'd5:  w = '{ACT_NOP,       C_NOT_DONE,  PC_W'(0),  1'b0};
      4'd6:  w = '{ACT_CLEAR,     C_CRC_BAD,   PC_W'(12), 1'b0};
      4'd7:  w = '{ACT_NOP,       C_PROTO_BAD, PC_W'(13), 1'b0};
      4'd8:  w = '{ACT_NOP,       C_NOT_TELEM, PC_W'(0),  1'b0};
      4'd9:  w = '{ACT_START_RUN, C_NEVER,     PC_W'(0),  1'b0};
      4'd10: w = '{ACT_EMIT_PAY,  C_NOT_LAST,  PC_W'(10), 1'b1};
      4'd11: w = '{ACT_NOP,       C_ALWAYS,    PC_W'(0),  1'b0};
      4'd12: w = '{ACT_EMIT_ERR,  C_ALWAYS,    PC_W'(0),  1'b1};
      4'd13: w = '{ACT_EMIT_ERR,  C_ALWAYS,    PC_W'(0),  1'b1};
      4'd14: w = '{ACT_HUNT,      C_ALWAYS,    PC_W'(0),  1'b0};
      4'd15: w = '{ACT_CLEAR,     C_ALWAYS,    PC_W'(0),  1'b0};
      default: w = '{ACT_NOP,     C_ALWAYS,    PC_W'(0),  1'b0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/crc16_frame_deframer_top.sv @@
// Start-mark / length / CRC-16 frame deframer.
// Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
// byte per transfer. Output channel (out_valid_o / out_ready_i) carries one
// result per transfer from an output register: an event code, a payload
// byte with its index, a last-of-run flag and the three frame counters.
// cfg_we_i writes one 8-bit register selected by cfg_index_i; the user must
// write it in idle only, as the block itself does not enforce this. A small
// microcode program steps a plain datapath; one step per cycle, except that a
// step that emits holds while the output register is full and not taken.
// Each received byte is worked through before the next one is taken. A good
// telemetry frame gives TELEMETRY_BYTES payload results at one per cycle while
// the receiver takes them, read from the frame buffer RAM one address per cycle.
// A stalled receiver holds the output register; input is still taken
// while the sequencer is back at its wait step, and a sequencer step
// that emits waits until the output register frees up.
// Reset clears the fill count, counters and output valid, sets the CRC to
// 0xFFFF and loads the default marks, version and type. No clearing pass.
`default_nettype none
module crc16_frame_deframer_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_index_i,
  input  wire logic [7:0]                cfg_wdata_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [7:0]                rx_byte_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [1:0]                     event_res_o,
  output logic [7:0]                     payload_data_o,
  output logic [crcdf_pkg::IDX_W-1:0]    payload_index_o,
  output logic                           last_of_run_o,
  output logic [crcdf_pkg::CNT_W-1:0]    crc_error_total_o,
  output logic [crcdf_pkg::CNT_W-1:0]    protocol_error_total_o,
  output logic [crcdf_pkg::CNT_W-1:0]    good_frame_total_o
);
  import crcdf_pkg::*;

  // control state
  logic [PC_W-1:0]   pc_q, pc_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [15:0]       crc_q, crc_d;
  logic [CNT_W-1:0]  crc_cnt_q, crc_cnt_d;
  logic [CNT_W-1:0]  proto_cnt_q, proto_cnt_d;
  logic [CNT_W-1:0]  good_cnt_q, good_cnt_d;
  logic [7:0]        mark1_q, mark2_q, ver_cfg_q, type_cfg_q;
  logic              out_valid_q, out_valid_d;

  // datapath
  logic [7:0]        byte_q, byte_d;
  logic [7:0]        prev_q, prev_d;
  logic [7:0]        ver_q, ver_d;
  logic [7:0]        type_q, type_d;
  logic [7:0]        plen_q, plen_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  event_e            ev_q, ev_d;
  logic [7:0]        od_q, od_d;
  logic [IDX_W-1:0]  oidx_q, oidx_d;
  logic              olast_q, olast_d;
  logic [CNT_W-1:0]  oc0_q, oc0_d, oc1_q, oc1_d, oc2_q, oc2_d;

  ucode_t            uw;
  logic              fire;
  logic              cond_true;
  logic              accept;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [LEN_W-1:0]  fill_ext, crc_end, frame_end;

  assign uw        = ucode_rom(pc_q);
  assign fire      = !uw.wait_out || !out_valid_q || out_ready_i;
  assign in_ready_o = (uw.act == ACT_ACCEPT);
  assign accept    = in_valid_i && in_ready_o;
  assign fill_ext  = LEN_W'(fill_q);
  assign crc_end   = LEN_W'(HDR_BYTES) + LEN_W'(plen_q);
  assign frame_end = crc_end + LEN_W'(CRC_TAIL_BYTES);

  // condition select
  always_comb begin
    case (uw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_NO_INPUT:  cond_true = !accept;
      C_FILL_LT2:  cond_true = (fill_q < FILL_W'(2));
      C_FILL_FULL: cond_true = (fill_q >= FILL_W'(MAX_FRAME_BYTES));
      C_LEN_BAD:   cond_true = (fill_q >= FILL_W'(HDR_BYTES)) &&
                               (LEN_W'(plen_q) > LEN_W'(MAX_PAYLOAD_BYTES));
      C_NOT_DONE:  cond_true = (fill_q < FILL_W'(HDR_BYTES)) || (fill_ext < frame_end);
      C_CRC_BAD:   cond_true = ({byte_q, prev_q} != crc_q);
      C_PROTO_BAD: cond_true = (ver_q != ver_cfg_q) || (type_q != type_cfg_q);
      C_NOT_TELEM: cond_true = (LEN_W'(plen_q) != LEN_W'(TELEMETRY_BYTES));
      C_NOT_LAST:  cond_true = (idx_q != IDX_W'(TELEMETRY_BYTES - 1));
      default:     cond_true = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (uw.wait_out && !fire) begin
      pc_d = pc_q;
    end else if (cond_true) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + PC_W'(1);
    end
  end

  // step actions
  always_comb begin
    fill_d      = fill_q;
    crc_d       = crc_q;
    crc_cnt_d   = crc_cnt_q;
    proto_cnt_d = proto_cnt_q;
    good_cnt_d  = good_cnt_q;
    byte_d      = byte_q;
    prev_d      = prev_q;
    ver_d       = ver_q;
    type_d      = type_q;
    plen_d      = plen_q;
    idx_d       = idx_q;
    ram_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    ev_d        = ev_q;
    od_d        = od_q;
    oidx_d      = oidx_q;
    olast_d     = olast_q;
    oc0_d       = oc0_q;
    oc1_d       = oc1_q;
    oc2_d       = oc2_q;

    case (uw.act)
      ACT_ACCEPT: begin
        if (accept) begin
          prev_d = byte_q;
          byte_d = rx_byte_i;
        end
      end
      ACT_HUNT: begin
        if (fill_q == FILL_W'(0)) begin
          if (byte_q == mark1_q) fill_d = FILL_W'(1);
        end else if (byte_q == mark2_q) begin
          fill_d = FILL_W'(2);
          crc_d  = CRC_INIT;
        end else begin
          fill_d = (byte_q == mark1_q) ? FILL_W'(1) : FILL_W'(0);
        end
      end
      ACT_STORE: begin
        ram_we = 1'b1;
        if (fill_q == FILL_W'(2)) ver_d  = byte_q;
        if (fill_q == FILL_W'(3)) type_d = byte_q;
        if (fill_q == FILL_W'(5)) plen_d = byte_q;
        // length byte itself is fed while fill is below the header size
        if ((fill_q < FILL_W'(HDR_BYTES)) || (fill_ext < crc_end)) begin
          crc_d = crc_feed(crc_q, byte_q);
        end
        fill_d = fill_q + FILL_W'(1);
      end
      ACT_CLEAR: begin
        fill_d = FILL_W'(0);
      end
      ACT_START_RUN: begin
        good_cnt_d = good_cnt_q + CNT_W'(1);
        idx_d      = IDX_W'(0);
      end
      ACT_EMIT_PAY: begin
        if (fire) begin
          out_valid_d = 1'b1;
          ev_d    = EV_PAYLOAD;
          od_d    = ram_rdata;
          oidx_d  = idx_q;
          olast_d = (idx_q == IDX_W'(TELEMETRY_BYTES - 1));
          oc0_d   = crc_cnt_q;
          oc1_d   = proto_cnt_q;
          oc2_d   = good_cnt_q;
          idx_d   = idx_q + IDX_W'(1);
        end
      end
      ACT_EMIT_ERR: begin
        if (fire) begin
          out_valid_d = 1'b1;
          od_d    = 8'h00;
          oidx_d  = IDX_W'(0);
          olast_d = 1'b1;
          oc2_d   = good_cnt_q;
          // CRC error step sits just below the protocol error step
          if (pc_q == PC_W'(12)) begin
            ev_d      = EV_CRC_ERR;
            crc_cnt_d = crc_cnt_q + CNT_W'(1);
            oc0_d     = crc_cnt_q + CNT_W'(1);
            oc1_d     = proto_cnt_q;
          end else begin
            ev_d        = EV_PROTO_ERR;
            proto_cnt_d = proto_cnt_q + CNT_W'(1);
            oc0_d       = crc_cnt_q;
            oc1_d       = proto_cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // read address follows the next index so data lines up with idx_q
  assign ram_raddr = ADDR_W'(HDR_BYTES) + ADDR_W'(idx_d);

  crcdf_ram #(
    .WIDTH(8),
    .DEPTH(MAX_FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (fill_q[ADDR_W-1:0]),
    .wdata_i (byte_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= PC_W'(0);
      fill_q      <= FILL_W'(0);
      crc_q       <= CRC_INIT;
      crc_cnt_q   <= CNT_W'(0);
      proto_cnt_q <= CNT_W'(0);
      good_cnt_q  <= CNT_W'(0);
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      fill_q      <= fill_d;
      crc_q       <= crc_d;
      crc_cnt_q   <= crc_cnt_d;
      proto_cnt_q <= proto_cnt_d;
      good_cnt_q  <= good_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark1_q    <= 8'hA5;
      mark2_q    <= 8'h5A;
      ver_cfg_q  <= 8'h01;
      type_cfg_q <= 8'h02;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MARK_FIRST:  mark1_q    <= cfg_wdata_i;
        CFG_MARK_SECOND: mark2_q    <= cfg_wdata_i;
        CFG_VERSION:     ver_cfg_q  <= cfg_wdata_i;
        CFG_TYPE_CODE:   type_cfg_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    prev_q  <= prev_d;
    ver_q   <= ver_d;
    type_q  <= type_d;
    plen_q  <= plen_d;
    idx_q   <= idx_d;
    ev_q    <= ev_d;
    od_q    <= od_d;
    oidx_q  <= oidx_d;
    olast_q <= olast_d;
    oc0_q   <= oc0_d;
    oc1_q   <= oc1_d;
    oc2_q   <= oc2_d;
  end

  assign out_valid_o            = out_valid_q;
  assign event_res_o            = ev_q;
  assign payload_data_o         = od_q;
  assign payload_index_o        = oidx_q;
  assign last_of_run_o          = olast_q;
  assign crc_error_total_o      = oc0_q;
  assign protocol_error_total_o = oc1_q;
  assign good_frame_total_o     = oc2_q;

endmodule
`default_nettype wire

@@ rtl/crcdf_ram.sv @@
`default_nettype none
module crcdf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
